/* rtl/cer_pkg.sv */
// Shared constants for the cylinder eta range unit.
// No dependencies; used by every other file of the block.
package cer_pkg;

   // Default parameter values
   localparam int ETA_FRAC_BITS_DEF = 12;
   localparam int LEN_BITS_DEF      = 17;

   // Fixed field widths
   localparam int RAD_BITS = 15;
   localparam int ETA_W    = 16;

   // Normalization target: the larger of |z| and r gets its MSB at this bit
   localparam int NORM_TOP = 30;
   localparam int NORM_W   = NORM_TOP + 1;

   // Square root: one result bit per stage
   localparam int SQRT_STAGES = 32;

   // log2 in Q.28 by repeated squaring, one fraction bit per stage
   localparam int LOG_FB  = 28;
   localparam int LOG_EW  = 6;
   localparam int LOG_W   = LOG_EW + LOG_FB;
   localparam int LOG_LAT = 2 + LOG_FB;

   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
   localparam logic [31:0] D_MAX   = 32'(12) << LOG_FB;

   // Stage counts: front end 5, root, add, log, difference, product, result
   localparam int ETA_LAT = 5 + SQRT_STAGES + 1 + LOG_LAT + 3;
   localparam int TOP_LAT = 1 + ETA_LAT;

endpackage

/* rtl/cer_channels.sv */
// Request and response channel interfaces of the cylinder eta range unit.
// Depends on cer_pkg for the fixed field widths.
interface cer_req_if #(
   parameter int LEN_BITS = cer_pkg::LEN_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [LEN_BITS-1:0]   z_start;
   logic [LEN_BITS-1:0]          z_span;
   logic [cer_pkg::RAD_BITS-1:0] radius_inner;
   logic [cer_pkg::RAD_BITS-1:0] radius_width;
   logic                         is_upright;

   modport source (output valid, z_start, z_span, radius_inner, radius_width, is_upright,
                   input ready);
   modport sink   (input valid, z_start, z_span, radius_inner, radius_width, is_upright,
                   output ready);
endinterface

interface cer_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [cer_pkg::ETA_W-1:0] eta_first;
   logic signed [cer_pkg::ETA_W-1:0] eta_second;
   logic                             clipped;

   modport source (output valid, eta_first, eta_second, clipped, input ready);
   modport sink   (input valid, eta_first, eta_second, clipped, output ready);
endinterface

/* rtl/cylinder_eta_range_unit.sv */
// Depth: 72 register stages. Throughput: one element per cycle; a stalled response freezes
// the whole pipeline (the output register holds), and the request side is ready whenever
// it moves. The depth is set mainly by the 32-stage square root and the 30-stage log2 units.
// Reset clears the valid line only; data registers carry no reset.
module cylinder_eta_range_unit #(
   parameter int ETA_FRAC_BITS = cer_pkg::ETA_FRAC_BITS_DEF,
   parameter int LEN_BITS      = cer_pkg::LEN_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   cer_req_if.sink   req_chan,
   cer_rsp_if.source rsp_chan
);
   import cer_pkg::*;

   localparam int ZW = LEN_BITS + 3;
   localparam int RW = RAD_BITS + 2;

   logic                 vld_ff [0:TOP_LAT-1];
   logic                 adv;
   logic signed [ZW-1:0] z0x, z1x, spx, zmid;
   logic [RW-1:0]        ri2, rout2, rmid2;
   logic                 straddle;
   logic signed [ZW-1:0] za_ff, zb_ff, za_in, zb_in;
   logic [RW-1:0]        ra_ff, rb_ff, ra_in, rb_in;
   logic [ETA_W-1:0]     eta_a, eta_b;
   logic                 clip_a, clip_b;

   // Move when the output register is empty or being taken
   assign adv            = !vld_ff[TOP_LAT-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Pick the two reference points, all lengths doubled
   always_comb begin
      z0x   = {{3{req_chan.z_start[LEN_BITS-1]}}, req_chan.z_start};
      spx   = {3'b000, req_chan.z_span};
      z1x   = z0x + spx;
      zmid  = (z0x <<< 1) + spx;
      ri2   = {req_chan.radius_inner, 1'b0};
      rout2 = {(RW-1)'(req_chan.radius_inner) + (RW-1)'(req_chan.radius_width), 1'b0};
      rmid2 = ri2 + RW'(req_chan.radius_width);
      straddle = z0x[ZW-1] && !z1x[ZW-1] && (z1x != '0);
      priority if (straddle) begin
         za_in = z0x <<< 1;
         zb_in = z1x <<< 1;
         ra_in = ri2;
         rb_in = ri2;
      end else if (req_chan.is_upright) begin
         za_in = zmid;
         zb_in = zmid;
         ra_in = rout2;
         rb_in = ri2;
      end else begin
         za_in = z0x <<< 1;
         zb_in = z1x <<< 1;
         ra_in = rmid2;
         rb_in = rmid2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         za_ff <= za_in;
         zb_ff <= zb_in;
         ra_ff <= ra_in;
         rb_ff <= rb_in;
      end
   end

   // Advance the valid line with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOP_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < TOP_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   cer_eta_pipe #(.ETA_FRAC_BITS(ETA_FRAC_BITS), .LEN_BITS(LEN_BITS)) u_eta_a (
      .clock (clock),
      .adv   (adv),
      .z_pt  (za_ff),
      .r_pt  (ra_ff),
      .eta   (eta_a),
      .clip  (clip_a)
   );

   cer_eta_pipe #(.ETA_FRAC_BITS(ETA_FRAC_BITS), .LEN_BITS(LEN_BITS)) u_eta_b (
      .clock (clock),
      .adv   (adv),
      .z_pt  (zb_ff),
      .r_pt  (rb_ff),
      .eta   (eta_b),
      .clip  (clip_b)
   );

   assign rsp_chan.valid      = vld_ff[TOP_LAT-1];
   assign rsp_chan.eta_first  = eta_a;
   assign rsp_chan.eta_second = eta_b;
   assign rsp_chan.clipped    = clip_a | clip_b;

   // A held response blocks intake
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while response stalled");

   // An empty output register never blocks intake
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("request blocked with empty output");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   // A frozen pipeline keeps its first and middle valid bits in place
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(vld_ff[0]) && $stable(vld_ff[TOP_LAT/2])))
      else $error("valid line moved during stall");

endmodule

/* rtl/cer_log2_pipe.sv */
// Pipelined log2 in unsigned Q.28: MSB search, normalize, then one squaring per stage.
// Depends on cer_pkg.
module cer_log2_pipe #(
   parameter int XW = 33
) (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [XW-1:0]             x,
   output logic [cer_pkg::LOG_W-1:0] lg
);
   import cer_pkg::*;

   localparam int EW = $clog2(XW);

   logic [XW-1:0]    x_ff;
   logic [EW-1:0]    e_ff;
   logic [EW-1:0]    e_in;
   logic [31:0]      m_ff  [0:LOG_FB];
   logic [LOG_W-1:0] lg_ff [0:LOG_FB];
   logic [31:0]      m0_in;
   logic [LOG_EW-1:0] e_w;
   logic [63:0]      x64;

   // Find the MSB index
   always_comb begin
      e_in = '0;
      for (int i = 0; i < XW; i++) begin
         if (x[i]) e_in = EW'(i);
      end
   end

   // Normalize the mantissa to Q1.31
   always_comb begin
      e_w = LOG_EW'(e_ff);
      x64 = 64'(x_ff);
      if (e_w <= LOG_EW'(31)) begin
         m0_in = 32'(x64 << (LOG_EW'(31) - e_w));
      end else begin
         m0_in = 32'(x64 >> (e_w - LOG_EW'(31)));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff     <= x;
         e_ff     <= e_in;
         m_ff[0]  <= m0_in;
         lg_ff[0] <= {e_w, {LOG_FB{1'b0}}};
      end
   end

   // Square and renormalize, one fraction bit per stage
   for (genvar i = 1; i <= LOG_FB; i++) begin : g_sq
      logic [63:0]      prod;
      logic [32:0]      t;
      logic [31:0]      m_in;
      logic [LOG_W-1:0] lg_in;
      always_comb begin
         prod  = 64'(m_ff[i-1]) * 64'(m_ff[i-1]);
         t     = prod[63:31];
         lg_in = lg_ff[i-1];
         if (t[32]) begin
            m_in              = t[32:1];
            lg_in[LOG_FB - i] = 1'b1;
         end else begin
            m_in = t[31:0];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            m_ff[i]  <= m_in;
            lg_ff[i] <= lg_in;
         end
      end
   end

   assign lg = lg_ff[LOG_FB];

endmodule

/* rtl/cer_eta_pipe.sv */
// Pipelined eta = asinh(z/r) of one reference point, Q4.ETA_FRAC_BITS, saturating.
// Depends on cer_pkg and cer_log2_pipe.
module cer_eta_pipe #(
   parameter int ETA_FRAC_BITS = cer_pkg::ETA_FRAC_BITS_DEF,
   parameter int LEN_BITS      = cer_pkg::LEN_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           adv,
   input  logic signed [LEN_BITS+2:0]     z_pt,
   input  logic [cer_pkg::RAD_BITS+1:0]   r_pt,
   output logic [cer_pkg::ETA_W-1:0]      eta,
   output logic                           clip
);
   import cer_pkg::*;

   localparam int ZW  = LEN_BITS + 3;
   localparam int AW  = LEN_BITS + 2;
   localparam int RW  = RAD_BITS + 2;
   localparam int MXW = (AW > RW) ? AW : RW;
   localparam int MSW = $clog2(MXW);
   localparam int XW  = NORM_W + 2;
   localparam logic [31:0] LIM = 32'(8) << ETA_FRAC_BITS;

   // flags: [1] negative z, [0] zero radius
   logic [1:0]        flg_ff [0:ETA_LAT-2];

   logic [AW-1:0]     a_ff, a2_ff;
   logic [RW-1:0]     b_ff, b2_ff;
   logic [AW-1:0]     a_in;
   logic [MXW-1:0]    mx;
   logic [MSW-1:0]    msb;
   logic [4:0]        sh_ff;
   logic [NORM_W-1:0] an_ff, bn_ff, an4_ff, bn4_ff;
   logic [61:0]       asq_ff, bsq_ff;
   logic [63:0]       sq_n_ff   [0:SQRT_STAGES];
   logic [63:0]       sq_res_ff [0:SQRT_STAGES];
   logic [NORM_W-1:0] sq_a_ff   [0:SQRT_STAGES];
   logic [NORM_W-1:0] sq_b_ff   [0:SQRT_STAGES];
   logic [XW-1:0]     x_ff;
   logic [NORM_W-1:0] bl_ff;
   logic [LOG_W-1:0]  lx, lb;
   logic [LOG_W-1:0]  d_full;
   logic [31:0]       d_ff;
   logic [63:0]       prod_ff;
   logic [64:0]       rnd;
   logic [31:0]       mag, sel;
   logic              sat;
   logic [1:0]        fl;
   logic [ETA_W-1:0]  eta_ff;
   logic              clip_ff;

   // Stage 1: magnitude of z and zero-radius flag
   assign a_in = z_pt[ZW-1] ? AW'(-z_pt) : AW'(z_pt);

   // Stage 2: MSB of the larger operand
   always_comb begin
      mx  = (MXW'(a_ff) > MXW'(b_ff)) ? MXW'(a_ff) : MXW'(b_ff);
      msb = '0;
      for (int i = 0; i < MXW; i++) begin
         if (mx[i]) msb = MSW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flg_ff[0] <= {z_pt[ZW-1], (r_pt == '0)};
         a_ff      <= a_in;
         b_ff      <= r_pt;
         // stage 2
         a2_ff     <= a_ff;
         b2_ff     <= b_ff;
         sh_ff     <= 5'(NORM_TOP - int'(msb));
         // stage 3: shift both left together
         an_ff     <= NORM_W'(a2_ff) << sh_ff;
         bn_ff     <= NORM_W'(b2_ff) << sh_ff;
         // stage 4: squares
         asq_ff    <= 62'(an_ff) * 62'(an_ff);
         bsq_ff    <= 62'(bn_ff) * 62'(bn_ff);
         an4_ff    <= an_ff;
         bn4_ff    <= bn_ff;
         // stage 5: sum of squares enters the root pipeline
         sq_n_ff[0]   <= 64'(asq_ff) + 64'(bsq_ff);
         sq_res_ff[0] <= '0;
         sq_a_ff[0]   <= an4_ff;
         sq_b_ff[0]   <= bn4_ff;
      end
   end

   // Advance the flag line
   for (genvar i = 1; i <= ETA_LAT - 2; i++) begin : g_flg
      always_ff @(posedge clock) begin
         if (adv) flg_ff[i] <= flg_ff[i-1];
      end
   end

   // Integer square root, one result bit per stage
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
      logic [63:0] trial;
      logic [63:0] n_in, res_in;
      always_comb begin
         trial = sq_res_ff[k] + BIT;
         if (sq_n_ff[k] >= trial) begin
            n_in   = sq_n_ff[k] - trial;
            res_in = (sq_res_ff[k] >> 1) + BIT;
         end else begin
            n_in   = sq_n_ff[k];
            res_in = sq_res_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_n_ff[k+1]   <= n_in;
            sq_res_ff[k+1] <= res_in;
            sq_a_ff[k+1]   <= sq_a_ff[k];
            sq_b_ff[k+1]   <= sq_b_ff[k];
         end
      end
   end

   // Form a + s
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff  <= XW'(sq_a_ff[SQRT_STAGES]) + XW'(sq_res_ff[SQRT_STAGES][31:0]);
         bl_ff <= sq_b_ff[SQRT_STAGES];
      end
   end

   cer_log2_pipe #(.XW(XW)) u_log_x (
      .clock (clock),
      .adv   (adv),
      .x     (x_ff),
      .lg    (lx)
   );

   cer_log2_pipe #(.XW(NORM_W)) u_log_b (
      .clock (clock),
      .adv   (adv),
      .x     (bl_ff),
      .lg    (lb)
   );

   // Log difference, clamp, scale by ln 2
   assign d_full = (lx > lb) ? (lx - lb) : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= (d_full > LOG_W'(D_MAX)) ? D_MAX : d_full[31:0];
         prod_ff <= 64'(d_ff) * 64'(LN2_Q32);
      end
   end

   // Round, saturate and apply the sign
   always_comb begin
      fl  = flg_ff[ETA_LAT-2];
      rnd = 65'(prod_ff) + (65'(1) << (59 - ETA_FRAC_BITS));
      mag = 32'(rnd >> (60 - ETA_FRAC_BITS));
      sat = fl[0] || (mag >= LIM);
      if (sat) begin
         sel = fl[1] ? LIM : (LIM - 32'd1);
      end else begin
         sel = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eta_ff  <= ETA_W'(fl[1] ? (32'd0 - sel) : sel);
         clip_ff <= sat;
      end
   end

   assign eta  = eta_ff;
   assign clip = clip_ff;

endmodule
